// File: hdl/tod_pkg.sv
// Package for the time-of-day keeper: constants, command and register codes,
// and the structs passed between the pipeline modules. No dependencies.
package tod_pkg;

  // Field widths of the channels and the configuration port.
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned ADJ_W     = 6;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned DAY_W     = 3;
  localparam int unsigned MOD_W     = 11;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Time units.
  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned HOUR_PER_DAY  = 24;
  localparam int unsigned DAYS_PER_WEEK = 7;

  // Timestamp split: now = 1000 * quotient + remainder.
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned Y_W     = 26;          // hi * 536 + lo
  localparam int unsigned Q1_W    = 16;          // y / 1000
  localparam int unsigned NQ_W    = 23;          // now / 1000
  localparam int unsigned NM_W    = 10;          // now % 1000
  localparam int unsigned HI_MOD  = 536;         // 2^16 mod 1000
  localparam int unsigned HI_DIV  = 65;          // 2^16 div 1000
  localparam int unsigned WRAP_MOD = 296;        // 2^32 mod 1000
  localparam int unsigned WRAP_DIV = 4294967;    // 2^32 div 1000
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;  // ceil(2^36 / 1000)

  // Configuration reset values.
  localparam logic [MOD_W-1:0] SLEEP_START_RST = 11'd1425;
  localparam logic [MOD_W-1:0] WAKE_RST        = 11'd300;
  localparam logic [MOD_W-1:0] DEEP_LEAD_RST   = 11'd30;
  localparam logic [DUR_W-1:0] DEEP_MAX_RST    = 16'd3600;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_ADD_MIN  = 3'd1,
    CMD_SUB_MIN  = 3'd2,
    CMD_ADD_HOUR = 3'd3,
    CMD_SUB_HOUR = 3'd4,
    CMD_SET_DAY  = 3'd5,
    CMD_LOAD     = 3'd6
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLEEP_START = 2'd0,
    CFG_WAKE        = 2'd1,
    CFG_DEEP_LEAD   = 2'd2,
    CFG_DEEP_MAX    = 2'd3
  } cfg_idx_e;

  // Command fields carried alongside the timestamp split.
  typedef struct packed {
    cmd_e              command;
    logic [ADJ_W-1:0]  adjust_value;
    logic [HOUR_W-1:0] load_hour;
    logic [MIN_W-1:0]  load_minute;
    logic [SEC_W-1:0]  load_second;
    logic [DAY_W-1:0]  load_day;
  } tod_ctl_t;

  // Command with its timestamp as quotient and remainder of 1000.
  typedef struct packed {
    tod_ctl_t          ctl;
    logic [NQ_W-1:0]   nq;
    logic [NM_W-1:0]   nm;
  } tod_stamp_t;

  // Time after a step and the tick pulses.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [DAY_W-1:0]  day;
    logic              p_sec;
    logic              p_min;
    logic              p_day;
  } tod_res_t;

endpackage

// File: hdl/tod_if.sv
// Valid/ready channel interfaces for the command input and the result output.
// Depends on tod_pkg for the field widths.
interface tod_in_if;
  logic                          valid;
  logic                          ready;
  logic [tod_pkg::CMD_W-1:0]     command;
  logic [tod_pkg::STAMP_W-1:0]   now_ms;
  logic [tod_pkg::ADJ_W-1:0]     adjust_value;
  logic [tod_pkg::HOUR_W-1:0]    load_hour;
  logic [tod_pkg::MIN_W-1:0]     load_minute;
  logic [tod_pkg::SEC_W-1:0]     load_second;
  logic [tod_pkg::DAY_W-1:0]     load_day;

  modport source (
    output valid, command, now_ms, adjust_value, load_hour, load_minute,
           load_second, load_day,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, adjust_value, load_hour, load_minute,
           load_second, load_day,
    output ready
  );
endinterface

interface tod_out_if;
  logic                          valid;
  logic                          ready;
  logic [tod_pkg::HOUR_W-1:0]    hour_now;
  logic [tod_pkg::MIN_W-1:0]     minute_now;
  logic [tod_pkg::SEC_W-1:0]     second_now;
  logic [tod_pkg::DAY_W-1:0]     day_now;
  logic                          second_pulse;
  logic                          minute_pulse;
  logic                          day_pulse;
  logic                          sleep_wanted;
  logic [tod_pkg::DUR_W-1:0]     deep_sleep_seconds;

  modport source (
    output valid, hour_now, minute_now, second_now, day_now, second_pulse,
           minute_pulse, day_pulse, sleep_wanted, deep_sleep_seconds,
    input  ready
  );
  modport sink (
    input  valid, hour_now, minute_now, second_now, day_now, second_pulse,
           minute_pulse, day_pulse, sleep_wanted, deep_sleep_seconds,
    output ready
  );
endinterface

// File: hdl/time_of_day_keeper_with_sleep_window_top.sv
// Top level of the time-of-day keeper with sleep window.
// Depends on tod_pkg, tod_if, tod_div, tod_core and tod_sleep.
//
//   Channel   Direction  Handshake        Carries
//   in_ch     in         valid / ready    command, timestamp, adjust and load fields
//   out_ch    out        valid / ready    time, tick pulses, sleep flag, deep sleep
//   cfg_*     in         write enable     register index and data, no read-back
//
// One command is taken per cycle while out_ch is not stalled. A command passes
// the input register, three more timestamp-split stages, the state update
// register and the output register before its result is offered on out_ch.
// Every stage moves on when the next one is empty or moving,
// so a stalled output fills the pipeline before in_ch.ready drops.
// Reset clears all valid bits, loads the time 00:00:00 on day 1 and the
// register defaults; no clearing pass follows.
module time_of_day_keeper_with_sleep_window_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  tod_pkg::cfg_idx_e             cfg_index_i,
  input  logic [tod_pkg::CFG_DAT_W-1:0] cfg_data_i,
  tod_in_if.sink                        in_ch,
  tod_out_if.source                     out_ch
);
  import tod_pkg::*;

  logic       stamp_valid, stamp_ready;
  tod_stamp_t stamp;
  logic       res_valid, res_ready;
  tod_res_t   res;

  // Timestamp split into quotient and remainder of 1000.
  tod_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .stamp_valid_o (stamp_valid),
    .stamp_ready_i (stamp_ready),
    .stamp_o       (stamp)
  );

  // Time state and command update.
  tod_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stamp_valid_i (stamp_valid),
    .stamp_ready_o (stamp_ready),
    .stamp_i       (stamp),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Sleep evaluation and output register.
  tod_sleep u_sleep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_ch      (out_ch)
  );

endmodule

// File: hdl/tod_div.sv
// Input register and a three-stage split of the millisecond timestamp into
// quotient and remainder of 1000. Depends on tod_pkg and tod_in_if.
module tod_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  tod_in_if.sink              in_ch,
  output logic                stamp_valid_o,
  input  logic                stamp_ready_i,
  output tod_pkg::tod_stamp_t stamp_o
);
  import tod_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  tod_ctl_t              ctl1_q, ctl2_q, ctl3_q;
  logic [STAMP_W-1:0]    now1_q;
  logic [Y_W-1:0]        y2_d, y2_q, y3_q;
  logic [HALF_W-1:0]     hi2_q, hi3_q;
  logic [Y_W+RECIP_W-1:0] prod;
  logic [Q1_W-1:0]       q3_d, q3_q;
  logic [Y_W-1:0]        rem_wide;
  tod_stamp_t            stamp_d, stamp_q;

  // A stage takes a new transfer when it is empty or its content moves on.
  assign rdy4 = !v4_q || stamp_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_ch.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Fold the upper half: now = 1000 * 65 * hi + (536 * hi + lo).
  assign y2_d = Y_W'(now1_q[STAMP_W-1:HALF_W]) * Y_W'(HI_MOD) + Y_W'(now1_q[HALF_W-1:0]);

  // Reciprocal multiply gives y / 1000 exactly over the range of y.
  assign prod = (Y_W+RECIP_W)'(y2_q) * (Y_W+RECIP_W)'(RECIP);
  assign q3_d = prod[RECIP_SHIFT +: Q1_W];

  // Remainder and full quotient of the timestamp.
  assign rem_wide = y3_q - Y_W'(q3_q) * Y_W'(MS_PER_SEC);
  always_comb begin
    stamp_d.ctl = ctl3_q;
    stamp_d.nq  = NQ_W'(hi3_q) * NQ_W'(HI_DIV) + NQ_W'(q3_q);
    stamp_d.nm  = rem_wide[NM_W-1:0];
  end

  // Payload registers follow their stage's enable.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ctl1_q.command      <= cmd_e'(in_ch.command);
      ctl1_q.adjust_value <= in_ch.adjust_value;
      ctl1_q.load_hour    <= in_ch.load_hour;
      ctl1_q.load_minute  <= in_ch.load_minute;
      ctl1_q.load_second  <= in_ch.load_second;
      ctl1_q.load_day     <= in_ch.load_day;
      now1_q              <= in_ch.now_ms;
    end
    if (rdy2) begin
      ctl2_q <= ctl1_q;
      y2_q   <= y2_d;
      hi2_q  <= now1_q[STAMP_W-1:HALF_W];
    end
    if (rdy3) begin
      ctl3_q <= ctl2_q;
      y3_q   <= y2_q;
      hi3_q  <= hi2_q;
      q3_q   <= q3_d;
    end
    if (rdy4) begin
      stamp_q <= stamp_d;
    end
  end

  assign stamp_valid_o = v4_q;
  assign stamp_o       = stamp_q;

endmodule

// File: hdl/tod_core.sv
// Time-of-day state and the next-state update for every command, with a
// result register behind it. Depends on tod_pkg.
module tod_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stamp_valid_i,
  output logic                stamp_ready_o,
  input  tod_pkg::tod_stamp_t stamp_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tod_pkg::tod_res_t   res_o
);
  import tod_pkg::*;

  // Last timestamp kept as quotient and remainder of 1000.
  logic [NQ_W-1:0]   lq_q, lq_d;
  logic [NM_W-1:0]   lm_q, lm_d;
  logic [NM_W-1:0]   rem_q, rem_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  logic [MIN_W-1:0]  min_q, min_d;
  logic [HOUR_W-1:0] hour_q, hour_d;
  logic [DAY_W-1:0]  day_q, day_d;
  logic              rv_q;
  tod_res_t          res_q, res_d;
  logic              advance;

  logic              borrow;
  logic [11:0]       x_off;
  logic [1:0]        f_off;
  logic [NM_W-1:0]   rm;
  logic [23:0]       secs;
  logic [6:0]        secs_c;
  logic [7:0]        s_sum, s_wrap;
  logic [ADJ_W-1:0]  adj_min, adj_hour;
  logic [MIN_W:0]    m_add;
  logic [HOUR_W:0]   h_add;
  logic [DAY_W-1:0]  day_fixed;
  logic              p_sec, p_min, p_day;

  assign stamp_ready_o = !rv_q || res_ready_i;
  assign advance       = stamp_valid_i && stamp_ready_o;

  // Elapsed time split: total = 1000 * secs + rm, with the 2^32 wrap folded in.
  always_comb begin
    borrow = (stamp_i.nq < lq_q) || ((stamp_i.nq == lq_q) && (stamp_i.nm < lm_q));
    x_off  = 12'(rem_q) + 12'(stamp_i.nm) + 12'(MS_PER_SEC) - 12'(lm_q)
             + (borrow ? 12'(WRAP_MOD) : 12'd0);
    if (x_off >= 12'(3 * MS_PER_SEC)) begin
      f_off = 2'd3;
      rm    = NM_W'(x_off - 12'(3 * MS_PER_SEC));
    end else if (x_off >= 12'(2 * MS_PER_SEC)) begin
      f_off = 2'd2;
      rm    = NM_W'(x_off - 12'(2 * MS_PER_SEC));
    end else if (x_off >= 12'(MS_PER_SEC)) begin
      f_off = 2'd1;
      rm    = NM_W'(x_off - 12'(MS_PER_SEC));
    end else begin
      f_off = 2'd0;
      rm    = NM_W'(x_off);
    end
    secs   = 24'(stamp_i.nq) - 24'(lq_q) + (borrow ? 24'(WRAP_DIV) : 24'd0)
             + 24'(f_off) - 24'd1;
    secs_c = (|secs[23:7]) ? 7'h7f : secs[6:0];
    s_sum  = 8'(sec_q) + 8'(secs_c);
    s_wrap = s_sum - 8'(SEC_PER_MIN);
  end

  // Clamped adjust amounts and the day code.
  always_comb begin
    adj_min   = (stamp_i.ctl.adjust_value > ADJ_W'(MIN_PER_HOUR - 1)) ?
                ADJ_W'(MIN_PER_HOUR - 1) : stamp_i.ctl.adjust_value;
    adj_hour  = (stamp_i.ctl.adjust_value > ADJ_W'(HOUR_PER_DAY - 1)) ?
                ADJ_W'(HOUR_PER_DAY - 1) : stamp_i.ctl.adjust_value;
    m_add     = (MIN_W+1)'(min_q) + (MIN_W+1)'(adj_min);
    h_add     = (HOUR_W+1)'(hour_q) + (HOUR_W+1)'(adj_hour);
    day_fixed = (stamp_i.ctl.load_day == '0) ? DAY_W'(1) : stamp_i.ctl.load_day;
  end

  // Next state for each command.
  always_comb begin
    lq_d   = lq_q;
    lm_d   = lm_q;
    rem_d  = rem_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    day_d  = day_q;
    p_sec  = 1'b0;
    p_min  = 1'b0;
    p_day  = 1'b0;
    case (stamp_i.ctl.command)
      CMD_TICK: begin
        lq_d  = stamp_i.nq;
        lm_d  = stamp_i.nm;
        rem_d = rm;
        if (secs != '0) begin
          p_sec = 1'b1;
          if (s_sum < 8'(SEC_PER_MIN)) begin
            sec_d = s_sum[SEC_W-1:0];
          end else begin
            // One minute carry at most; the seconds saturate beyond that.
            sec_d = (s_wrap >= 8'(SEC_PER_MIN)) ? SEC_W'(SEC_PER_MIN - 1) : s_wrap[SEC_W-1:0];
            p_min = 1'b1;
            if (min_q == MIN_W'(MIN_PER_HOUR - 1)) begin
              min_d = '0;
              if (hour_q == HOUR_W'(HOUR_PER_DAY - 1)) begin
                hour_d = '0;
                p_day  = 1'b1;
                day_d  = (day_q == DAY_W'(DAYS_PER_WEEK)) ? DAY_W'(1) : day_q + DAY_W'(1);
              end else begin
                hour_d = hour_q + HOUR_W'(1);
              end
            end else begin
              min_d = min_q + MIN_W'(1);
            end
          end
        end
      end
      CMD_ADD_MIN: begin
        min_d = (m_add >= (MIN_W+1)'(MIN_PER_HOUR)) ?
                MIN_W'(m_add - (MIN_W+1)'(MIN_PER_HOUR)) : MIN_W'(m_add);
      end
      CMD_SUB_MIN: begin
        min_d = (min_q >= adj_min) ? min_q - adj_min :
                MIN_W'(min_q + MIN_W'(MIN_PER_HOUR) - adj_min);
      end
      CMD_ADD_HOUR: begin
        hour_d = (h_add >= (HOUR_W+1)'(HOUR_PER_DAY)) ?
                 HOUR_W'(h_add - (HOUR_W+1)'(HOUR_PER_DAY)) : HOUR_W'(h_add);
      end
      CMD_SUB_HOUR: begin
        hour_d = (ADJ_W'(hour_q) >= adj_hour) ? HOUR_W'(ADJ_W'(hour_q) - adj_hour) :
                 HOUR_W'(ADJ_W'(hour_q) + ADJ_W'(HOUR_PER_DAY) - adj_hour);
      end
      CMD_SET_DAY: begin
        day_d = day_fixed;
      end
      CMD_LOAD: begin
        lq_d   = stamp_i.nq;
        lm_d   = stamp_i.nm;
        rem_d  = '0;
        hour_d = (stamp_i.ctl.load_hour > HOUR_W'(HOUR_PER_DAY - 1)) ?
                 HOUR_W'(HOUR_PER_DAY - 1) : stamp_i.ctl.load_hour;
        min_d  = (stamp_i.ctl.load_minute > MIN_W'(MIN_PER_HOUR - 1)) ?
                 MIN_W'(MIN_PER_HOUR - 1) : stamp_i.ctl.load_minute;
        sec_d  = (stamp_i.ctl.load_second > SEC_W'(SEC_PER_MIN - 1)) ?
                 SEC_W'(SEC_PER_MIN - 1) : stamp_i.ctl.load_second;
        day_d  = day_fixed;
      end
      default: begin
        // Unused code: no change of state.
      end
    endcase
  end

  always_comb begin
    res_d.hour   = hour_d;
    res_d.minute = min_d;
    res_d.second = sec_d;
    res_d.day    = day_d;
    res_d.p_sec  = p_sec;
    res_d.p_min  = p_min;
    res_d.p_day  = p_day;
  end

  // State registers change only when a command transfers in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lq_q   <= '0;
      lm_q   <= '0;
      rem_q  <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      day_q  <= DAY_W'(1);
      rv_q   <= 1'b0;
    end else begin
      if (advance) begin
        lq_q   <= lq_d;
        lm_q   <= lm_d;
        rem_q  <= rem_d;
        sec_q  <= sec_d;
        min_q  <= min_d;
        hour_q <= hour_d;
        day_q  <= day_d;
      end
      if (stamp_ready_o) rv_q <= stamp_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

// File: hdl/tod_sleep.sv
// Configuration registers, sleep-window and deep-sleep evaluation, and the
// output register. Depends on tod_pkg and tod_out_if.
module tod_sleep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  tod_pkg::cfg_idx_e            cfg_index_i,
  input  logic [tod_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                         res_valid_i,
  output logic                         res_ready_o,
  input  tod_pkg::tod_res_t            res_i,
  tod_out_if.source                    out_ch
);
  import tod_pkg::*;

  logic [MOD_W-1:0] sleep_start_q, wake_q, lead_q;
  logic [DUR_W-1:0] deep_max_q;

  logic [MOD_W-1:0] tod_min, end_min, gap;
  logic [16:0]      gap_s;
  logic             lead_over;
  logic             sleep_d;
  logic [DUR_W-1:0] deep_d;

  logic             ov_q;
  tod_res_t         res_q;
  logic             sleep_q;
  logic [DUR_W-1:0] deep_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_start_q <= SLEEP_START_RST;
      wake_q        <= WAKE_RST;
      lead_q        <= DEEP_LEAD_RST;
      deep_max_q    <= DEEP_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLEEP_START: sleep_start_q <= cfg_data_i[MOD_W-1:0];
        CFG_WAKE:        wake_q        <= cfg_data_i[MOD_W-1:0];
        CFG_DEEP_LEAD:   lead_q        <= cfg_data_i[MOD_W-1:0];
        CFG_DEEP_MAX:    deep_max_q    <= cfg_data_i[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Minute of day, the sleep window and the allowed deep sleep.
  always_comb begin
    tod_min   = MOD_W'(res_i.hour) * MOD_W'(MIN_PER_HOUR) + MOD_W'(res_i.minute);
    sleep_d   = (tod_min < wake_q) || (tod_min > sleep_start_q);
    lead_over = lead_q > wake_q;
    end_min   = wake_q - lead_q;
    gap       = end_min - tod_min;
    gap_s     = 17'(gap) * 17'(SEC_PER_MIN);
    if (tod_min > sleep_start_q) begin
      deep_d = deep_max_q;
    end else if (lead_over || (tod_min > end_min)) begin
      deep_d = '0;
    end else if (gap_s > 17'(deep_max_q)) begin
      deep_d = deep_max_q;
    end else begin
      deep_d = gap_s[DUR_W-1:0];
    end
  end

  // Output register parts the pipeline from the consumer.
  assign res_ready_o = !ov_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res_ready_o) begin
      ov_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o) begin
      res_q   <= res_i;
      sleep_q <= sleep_d;
      deep_q  <= deep_d;
    end
  end

  assign out_ch.valid              = ov_q;
  assign out_ch.hour_now           = res_q.hour;
  assign out_ch.minute_now         = res_q.minute;
  assign out_ch.second_now         = res_q.second;
  assign out_ch.day_now            = res_q.day;
  assign out_ch.second_pulse       = res_q.p_sec;
  assign out_ch.minute_pulse       = res_q.p_min;
  assign out_ch.day_pulse          = res_q.p_day;
  assign out_ch.sleep_wanted       = sleep_q;
  assign out_ch.deep_sleep_seconds = deep_q;

endmodule
